@@ hw/rtl/u8lw_pkg.sv @@
package u8lw_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    RegLineWidth  = 2'd0,
    RegNarrowWidth = 2'd1,
    RegWideWidth  = 2'd2,
    RegByteLimit  = 2'd3
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  // reset values of the configuration registers
  localparam logic [9:0] LineWidthRst  = 10'd128;
  localparam logic [6:0] NarrowWidthRst = 7'd8;
  localparam logic [6:0] WideWidthRst  = 7'd16;
  localparam logic [7:0] ByteLimitRst  = 8'd48;

  // result kinds
  localparam logic KindByte = 1'b0;
  localparam logic KindEol  = 1'b1;

  typedef struct packed {
    logic [9:0] line_width_px;
    logic [6:0] narrow_width_px;
    logic [6:0] wide_width_px;
    logic [7:0] line_byte_limit;
  } cfg_t;

  // one queue entry: everything a single text byte causes
  typedef struct packed {
    logic            brk;     // end of line before the bytes
    logic [2:0]      nbytes;  // text bytes to pass on, 0 to 4
    logic [3:0][7:0] bytes;
    logic            eol;     // end of line after the bytes
  } cmd_t;

endpackage

@@ hw/rtl/u8lw_front.sv @@
module u8lw_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  u8lw_pkg::cfg_t  cfg_i,
  input  logic            valid_i,
  input  logic [7:0]      text_byte_i,
  input  logic            end_of_text_i,
  output logic            cmd_push_o,
  output u8lw_pkg::cmd_t  cmd_o
);
  import u8lw_pkg::*;

  localparam logic [7:0] ByteLf = 8'h0A;
  localparam logic [7:0] ByteCr = 8'h0D;

  function automatic logic [1:0] lead_need(input logic [7:0] b);
    logic [1:0] need;
    need = 2'd0;
    if ((b & 8'hE0) == 8'hC0) begin
      need = 2'd1;
    end else if ((b & 8'hF0) == 8'hE0) begin
      need = 2'd2;
    end else if ((b & 8'hF8) == 8'hF0) begin
      need = 2'd3;
    end
    return need;
  endfunction

  logic [10:0] pos_q, pos_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [1:0]  need_q, need_d;
  logic [1:0]  hc_q, hc_d;
  logic [7:0]  held_q [3];
  logic        held_we;
  logic [1:0]  held_idx;
  cmd_t        cmd;

  always_comb begin : p_next
    logic        place;
    logic        fin;
    logic        do_brk;
    logic [6:0]  w;
    logic [2:0]  c;
    logic [1:0]  slot;
    logic [11:0] pos_sum;
    logic [8:0]  cnt_sum;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    need_d   = need_q;
    hc_d     = hc_q;
    held_we  = 1'b0;
    held_idx = hc_q;
    cmd      = '0;
    place    = 1'b0;
    fin      = 1'b0;
    w        = cfg_i.narrow_width_px;
    c        = 3'd1;
    slot     = 2'd0;
    if (text_byte_i == 8'h00) begin
      fin = 1'b1;
    end else begin
      if (need_q != 2'd0) begin
        // trailing byte
        need_d = need_q - 2'd1;
        if (need_q == 2'd1) begin
          place = 1'b1;
          w     = cfg_i.wide_width_px;
          c     = {1'b0, hc_q} + 3'd1;
          slot  = hc_q;
          hc_d  = 2'd0;
        end else begin
          held_we = 1'b1;
          hc_d    = hc_q + 2'd1;
        end
      end else if (!text_byte_i[7]) begin
        if (text_byte_i == ByteLf || text_byte_i == ByteCr) begin
          cmd.brk = (cnt_q != 8'd0);
          pos_d   = '0;
          cnt_d   = '0;
        end else begin
          place = 1'b1;
        end
      end else if (lead_need(text_byte_i) != 2'd0) begin
        held_we  = 1'b1;
        held_idx = 2'd0;
        hc_d     = 2'd1;
        need_d   = lead_need(text_byte_i);
      end
      fin = end_of_text_i;
    end

    pos_sum = {1'b0, pos_q} + 12'(w);
    cnt_sum = {1'b0, cnt_q} + 9'(c);
    do_brk  = place && (cnt_q != 8'd0) &&
              ((pos_sum > {2'b00, cfg_i.line_width_px}) ||
               (cnt_sum >= {1'b0, cfg_i.line_byte_limit}));
    if (place) begin
      cmd.brk    = do_brk;
      cmd.nbytes = c;
      for (int i = 0; i < 3; i++) begin
        cmd.bytes[i] = (2'(i) == slot) ? text_byte_i : held_q[i];
      end
      cmd.bytes[3] = text_byte_i;
      pos_d = do_brk ? 11'(w) : pos_sum[10:0];
      cnt_d = do_brk ? 8'(c) : cnt_sum[7:0];
    end
    if (fin) begin
      cmd.eol = (cnt_d != 8'd0);
      pos_d   = '0;
      cnt_d   = '0;
      need_d  = '0;
      hc_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      cnt_q  <= '0;
      need_q <= '0;
      hc_q   <= '0;
    end else if (valid_i) begin
      pos_q  <= pos_d;
      cnt_q  <= cnt_d;
      need_q <= need_d;
      hc_q   <= hc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && held_we && held_idx != 2'd3) begin
      held_q[held_idx] <= text_byte_i;
    end
  end

  assign cmd_o      = cmd;
  assign cmd_push_o = valid_i && (cmd.brk || cmd.nbytes != 3'd0 || cmd.eol);

  // a character is being assembled exactly when bytes are held
  a_need_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (need_q == 2'd0) == (hc_q == 2'd0))
    else $error("held count out of step with bytes still needed");

endmodule

@@ hw/rtl/u8lw_cmd_fifo.sv @@
module u8lw_cmd_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  u8lw_pkg::cmd_t  data_i,
  output logic            full_o,
  input  logic            pop_i,
  output u8lw_pkg::cmd_t  data_o,
  output logic            empty_o
);
  import u8lw_pkg::*;

  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [AW-1:0]   LastPtr  = AW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [AW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + AW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command pushed into a full queue");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthCnt)
    else $error("queue fill count beyond depth");

endmodule

@@ hw/rtl/u8lw_back.sv @@
module u8lw_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  u8lw_pkg::cmd_t  cmd_i,
  input  logic            cmd_empty_i,
  output logic            cmd_pop_o,
  output logic            empty_o,
  input  logic            pop_i,
  output logic            kind_o,
  output logic [7:0]      out_byte_o,
  output logic            last_of_run_o
);
  import u8lw_pkg::*;

  cmd_t       cur_q;
  logic       cur_valid_q;
  logic [2:0] idx_q;
  logic [2:0] cur_n;
  logic [2:0] j;
  logic       is_last;
  logic       pop_acc;
  logic       load;

  assign cur_n   = {2'b00, cur_q.brk} + cur_q.nbytes + {2'b00, cur_q.eol};
  assign j       = idx_q - {2'b00, cur_q.brk};
  assign is_last = (idx_q == cur_n - 3'd1);
  assign pop_acc = pop_i && cur_valid_q;
  assign load    = !cmd_empty_i && (!cur_valid_q || (pop_acc && is_last));

  assign empty_o       = !cur_valid_q;
  assign cmd_pop_o     = load;
  assign last_of_run_o = is_last;

  always_comb begin
    kind_o     = KindEol;
    out_byte_o = 8'h00;
    if (cur_q.brk && idx_q == 3'd0) begin
      kind_o = KindEol;
    end else if (j < cur_q.nbytes) begin
      kind_o     = KindByte;
      out_byte_o = cur_q.bytes[j[1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load) begin
      cur_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (pop_acc) begin
      cur_valid_q <= !is_last;
      idx_q       <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= cmd_i;
    end
  end

  a_cmd_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (cur_n != 3'd0))
    else $error("command without results reached the back end");

  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (idx_q < cur_n))
    else $error("result index ran past the command");

endmodule

@@ hw/rtl/utf8_text_line_wrapper.sv @@
// a text byte's first result reaches the result ports via the queue and the sequencer's register
// throughput: one byte per cycle in while the queue has room, one result per cycle out while popped
// a byte that causes n results (n from 1 to 6) holds the result side until all n are popped;
// the command queue between the byte decoder and the result sequencer absorbs the runs
// reset: line position, byte count and partial character cleared, queue emptied,
// configuration back to its default values; no clearing pass, usable at once
module utf8_text_line_wrapper #(
  parameter int unsigned CmdDepth = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [u8lw_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [u8lw_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // text bytes in
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      text_byte_i,
  input  logic                            end_of_text_i,
  // results out
  output logic                            empty,
  input  logic                            pop,
  output logic                            kind_o,
  output logic [7:0]                      out_byte_o,
  output logic                            last_of_run_o
);
  import u8lw_pkg::*;

  cfg_t cfg_q;
  logic in_acc;
  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_full;
  logic cmd_empty;
  logic cmd_pop;

  // configuration registers; the user must write them only while the block is idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_width_px   <= LineWidthRst;
      cfg_q.narrow_width_px <= NarrowWidthRst;
      cfg_q.wide_width_px   <= WideWidthRst;
      cfg_q.line_byte_limit <= ByteLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegLineWidth:   cfg_q.line_width_px   <= cfg_wdata_i[9:0];
        RegNarrowWidth: cfg_q.narrow_width_px <= cfg_wdata_i[6:0];
        RegWideWidth:   cfg_q.wide_width_px   <= cfg_wdata_i[6:0];
        RegByteLimit:   cfg_q.line_byte_limit <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // a byte is taken whenever the queue has room; the decoder never stalls otherwise
  assign full   = cmd_full;
  assign in_acc = push && !cmd_full;

  // decoder: classifies the byte, tracks line width and byte count, assembles
  // multi-byte characters and turns each byte into one command (or none)
  u8lw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .valid_i       (in_acc),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .cmd_push_o    (cmd_push),
    .cmd_o         (cmd_in)
  );

  // short command queue so decoder and sequencer stall independently
  u8lw_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // sequencer: plays one command out as a run of results, one transaction per cycle while results are popped
  u8lw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_out),
    .cmd_empty_i   (cmd_empty),
    .cmd_pop_o     (cmd_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .kind_o        (kind_o),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
